/* rtl/core/msss_pkg.sv */
// Package: shared types and constants for the multi-stack shared store unit.
package msss_pkg;

   localparam int DATA_W     = 32;
   localparam int STACK_ID_W = 2;
   localparam int STATUS_W   = 2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

/* rtl/core/multi_stack_shared_store_unit.sv */
// Several LIFO stacks that share one data store, with a free list threaded through a link memory.
//
// When a request is accepted, the link and data memories are read at the selected slot. In the
// execute state the read data come back, and a request that succeeds writes the link memory and,
// on a push, the data memory. The result appears in the cycle after the execute state, for one
// cycle, with rsp_valid high. busy is high in the execute state, so a new request can be taken
// in the same cycle that the previous result is shown. The receiver cannot stall. After reset, no
// clearing pass is needed: never-used slots are tracked by a fill count, and they link to the
// next slot up. Only the first four stacks can be addressed by req_stack_id. A stack number
// that is out of range answers full on a push and empty on a pop.
module multi_stack_shared_store_unit #(
   parameter int NUM_STACKS = 4,
   parameter int CAPACITY   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_mode,
   input  logic        [msss_pkg::STACK_ID_W-1:0] req_stack_id,
   input  logic signed [msss_pkg::DATA_W-1:0]     req_push_value,
   output logic                                   rsp_valid,
   output logic signed [msss_pkg::DATA_W-1:0]     rsp_pop_value,
   output logic        [msss_pkg::STATUS_W-1:0]   rsp_status
);
   import msss_pkg::*;

   localparam int PTR_W     = $clog2(CAPACITY + 1);
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int SID_SPAN  = 1 << STACK_ID_W;
   localparam int HEAD_USED = (NUM_STACKS < SID_SPAN) ? NUM_STACKS : SID_SPAN;
   localparam int HEAD_IW   = (HEAD_USED > 1) ? $clog2(HEAD_USED) : 1;
   localparam int HEAD_N    = 1 << HEAD_IW;

   localparam logic [PTR_W-1:0]      PTR_NONE  = PTR_W'(CAPACITY);
   localparam logic [STACK_ID_W:0]   SID_LIMIT = (STACK_ID_W + 1)'(HEAD_USED);

   // State memories
   logic [PTR_W-1:0]  link_mem [CAPACITY];
   logic [DATA_W-1:0] data_mem [CAPACITY];

   logic [PTR_W-1:0]  link_rd_ff;
   logic [DATA_W-1:0] data_rd_ff;

   logic [PTR_W-1:0]  heads_ff [HEAD_N];
   logic [PTR_W-1:0]  free_head_ff, free_head_in;
   logic [PTR_W-1:0]  fresh_ff, fresh_in;

   state_type state_ff, state_in;
   logic      exec;

   // Request registers
   logic               mode_ff;
   logic [HEAD_IW-1:0] idx_ff;
   logic [DATA_W-1:0]  value_ff;
   logic [PTR_W-1:0]   slot_ff;
   logic               ok_ff;

   // Result registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               sid_ok;
   logic [HEAD_IW-1:0] head_idx;
   logic [PTR_W-1:0]   slot_sel;
   logic               op_ok;
   logic [ADDR_W-1:0]  rd_addr;

   logic [ADDR_W-1:0]  wr_addr;
   logic [PTR_W-1:0]   link_eff;
   logic               head_wr;
   logic [PTR_W-1:0]   head_wr_val;
   logic               mem_wr;
   logic [PTR_W-1:0]   link_wr_val;

   // Request decode and read address
   always_comb begin
      accept   = start && !busy;
      sid_ok   = ({1'b0, req_stack_id} < SID_LIMIT);
      head_idx = req_stack_id[HEAD_IW-1:0];
      slot_sel = (req_mode == MODE_PUSH) ? free_head_ff : heads_ff[head_idx];
      op_ok    = sid_ok && (slot_sel < PTR_NONE);
      rd_addr  = op_ok ? slot_sel[ADDR_W-1:0] : '0;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      unique case (state_ff)
         ST_EXEC: exec = 1'b1;
         default: exec = 1'b0;
      endcase
   end

   assign busy = exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         idx_ff   <= head_idx;
         value_ff <= req_push_value;
         slot_ff  <= slot_sel;
         ok_ff    <= op_ok;
      end
   end

   // Execute: read data arrive, memories and pointers are updated
   always_comb begin
      wr_addr = slot_ff[ADDR_W-1:0];
      // a slot at or above the fill count was never written and links to the next slot up
      link_eff      = (slot_ff >= fresh_ff) ? (slot_ff + PTR_W'(1)) : link_rd_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      head_wr       = 1'b0;
      head_wr_val   = link_rd_ff;
      mem_wr        = 1'b0;
      link_wr_val   = free_head_ff;
      rsp_valid_in  = exec;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      if (mode_ff == MODE_PUSH) begin
         rsp_value_in = '0;
         if (!ok_ff) begin
            rsp_status_in = STATUS_FULL;
         end else if (exec) begin
            mem_wr       = 1'b1;
            link_wr_val  = heads_ff[idx_ff];
            head_wr      = 1'b1;
            head_wr_val  = slot_ff;
            free_head_in = link_eff;
            if (slot_ff == fresh_ff) fresh_in = fresh_ff + PTR_W'(1);
         end
      end else begin
         if (!ok_ff) begin
            rsp_value_in  = '1;
            rsp_status_in = STATUS_EMPTY;
         end else begin
            rsp_value_in = data_rd_ff;
            if (exec) begin
               mem_wr       = 1'b1;
               link_wr_val  = free_head_ff;
               head_wr      = 1'b1;
               head_wr_val  = link_rd_ff;
               free_head_in = slot_ff;
            end
         end
      end
   end

   // Memories: read on transfer, write during execute
   always_ff @(posedge clock) begin
      if (accept) begin
         link_rd_ff <= link_mem[rd_addr];
         data_rd_ff <= data_mem[rd_addr];
      end
      if (mem_wr) begin
         link_mem[wr_addr] <= link_wr_val;
         if (mode_ff == MODE_PUSH) data_mem[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HEAD_N; i++) heads_ff[i] <= PTR_NONE;
         free_head_ff <= '0;
         fresh_ff     <= '0;
      end else begin
         if (head_wr) heads_ff[idx_ff] <= head_wr_val;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   // Assertions
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("execute phase lasted more than one cycle");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("no result after execute phase");

   a_result_only_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding execute phase");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= PTR_NONE)
      else $error("fill count beyond capacity");

   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff <= fresh_ff) || (free_head_ff == PTR_NONE))
      else $error("free list head points past the fill count");

endmodule

/* tb/sv/tb_multi_stack_shared_store_unit.sv */
// Self-checking testbench for multi_stack_shared_store_unit: directed and random push/pop traffic.
`timescale 1ns / 100ps

module tb_multi_stack_shared_store_unit;
   import msss_pkg::*;

   localparam int NUM_STACKS = 4;
   localparam int CAPACITY   = 16;
   localparam int PTR_W      = $clog2(CAPACITY + 1);
   localparam int STALL_LIMIT = 1000;

   typedef struct {
      logic signed [DATA_W-1:0]   pop_value;
      logic        [STATUS_W-1:0] status;
   } stack_answer_type;

   // Shadow copy of the stacks; predicts the answer to every accepted request.
   class stack_shadow;
      logic [DATA_W-1:0] slot_data [CAPACITY];
      logic [PTR_W-1:0]  slot_link [CAPACITY];
      logic [PTR_W-1:0]  stack_top [NUM_STACKS];
      logic [PTR_W-1:0]  free_top;
      stack_answer_type  pending_answers [$];
      int                errors;

      function new();
         for (int i = 0; i < CAPACITY; i++) begin
            slot_data[i] = '0;
            slot_link[i] = PTR_W'(i + 1);
         end
         for (int i = 0; i < NUM_STACKS; i++) stack_top[i] = PTR_W'(CAPACITY);
         free_top = '0;
         errors = 0;
      endfunction

      function void note_request(logic mode, logic [STACK_ID_W-1:0] sid,
                                 logic [DATA_W-1:0] value);
         stack_answer_type answer;
         int               slot;
         if (mode == MODE_PUSH) begin
            answer.pop_value = '0;
            if (sid >= NUM_STACKS || free_top >= CAPACITY) begin
               answer.status = STATUS_FULL;
            end else begin
               slot = int'(free_top);
               free_top = slot_link[slot];
               slot_data[slot] = value;
               slot_link[slot] = stack_top[sid];
               stack_top[sid] = PTR_W'(slot);
               answer.status = STATUS_OK;
            end
         end else if (sid >= NUM_STACKS || stack_top[sid] >= CAPACITY) begin
            answer.pop_value = -1;
            answer.status = STATUS_EMPTY;
         end else begin
            slot = int'(stack_top[sid]);
            stack_top[sid] = slot_link[slot];
            slot_link[slot] = free_top;
            free_top = PTR_W'(slot);
            answer.pop_value = slot_data[slot];
            answer.status = STATUS_OK;
         end
         pending_answers.push_back(answer);
      endfunction

      function void check_result(logic signed [DATA_W-1:0] pop_value,
                                 logic [STATUS_W-1:0] status);
         stack_answer_type answer;
         if (pending_answers.size() == 0) begin
            $display("%0t: result with no request waiting: pop_value %0d status %0d",
                     $time, pop_value, status);
            errors++;
            return;
         end
         answer = pending_answers.pop_front();
         if (pop_value !== answer.pop_value) begin
            $display("%0t: pop_value expected %0d actual %0d",
                     $time, answer.pop_value, pop_value);
            errors++;
         end
         if (status !== answer.status) begin
            $display("%0t: status expected %0d actual %0d", $time, answer.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return pending_answers.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_mode = MODE_PUSH;
   logic        [STACK_ID_W-1:0] req_stack_id = '0;
   logic signed [DATA_W-1:0]     req_push_value = '0;
   logic                         rsp_valid;
   logic signed [DATA_W-1:0]     rsp_pop_value;
   logic        [STATUS_W-1:0]   rsp_status;

   stack_shadow shadow;
   int          stall_cycles = 0;

   multi_stack_shared_store_unit #(
      .NUM_STACKS(NUM_STACKS),
      .CAPACITY  (CAPACITY)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_stack_id  (req_stack_id),
      .req_push_value(req_push_value),
      .rsp_valid     (rsp_valid),
      .rsp_pop_value (rsp_pop_value),
      .rsp_status    (rsp_status)
   );

   always #10 clock = ~clock;

   // Result check comes first: a result never belongs to the request taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) shadow.check_result(rsp_pop_value, rsp_status);
         if (start && busy === 1'b0) shadow.note_request(req_mode, req_stack_id, req_push_value);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Holds the request until a transfer; start stays high afterwards.
   task automatic send_request(input logic mode, input logic [STACK_ID_W-1:0] sid,
                               input logic [DATA_W-1:0] value);
      start <= 1'b1;
      req_mode <= mode;
      req_stack_id <= sid;
      req_push_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [DATA_W-1:0] value;
      send_request(MODE_POP, 2'd0, '0);
      // fill the whole store across all stacks, extremes first
      for (int i = 0; i < CAPACITY; i++) begin
         case (i)
            0: value = 32'h7fff_ffff;
            1: value = 32'h8000_0000;
            2: value = 32'hffff_ffff;
            3: value = 32'h0000_0000;
            4: value = 32'h5555_5555;
            5: value = 32'haaaa_aaaa;
            default: value = $urandom;
         endcase
         send_request(MODE_PUSH, STACK_ID_W'(i % NUM_STACKS), value);
      end
      send_request(MODE_PUSH, 2'd1, 32'h1234_5678);
      for (int i = 0; i <= CAPACITY / NUM_STACKS; i++) send_request(MODE_POP, 2'd3, '0);
   endtask

   task automatic run_random(input int count, input bit allow_idle);
      int                    push_pct;
      int                    focus;
      bit                    idle_on;
      logic                  mode;
      logic [STACK_ID_W-1:0] sid;
      logic [DATA_W-1:0]     value;
      push_pct = 50;
      focus = NUM_STACKS;
      idle_on = 0;
      for (int i = 0; i < count; i++) begin
         // every 40 requests a new push percentage is drawn, so the store both fills and drains
         if (i % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: push_pct = 20;
               1: push_pct = 50;
               2: push_pct = 75;
               default: push_pct = 90;
            endcase
            focus = $urandom_range(0, NUM_STACKS);
            idle_on = allow_idle && ($urandom_range(0, 2) != 0);
         end
         mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
         if (focus < NUM_STACKS && $urandom_range(0, 1) == 1) sid = STACK_ID_W'(focus);
         else sid = STACK_ID_W'($urandom_range(0, NUM_STACKS - 1));
         case ($urandom_range(0, 9))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            2: value = 32'hffff_ffff;
            3: value = 32'h0000_0000;
            default: value = $urandom;
         endcase
         send_request(mode, sid, value);
         if (idle_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 14));
      end
   endtask

   initial begin
      shadow = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(1300, 1'b1);
      run_random(300, 1'b0);
      start <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
